### sv/zsxd_pkg.sv
// ----------------------------------------------------------------------------
// zsxd_pkg
// Types and constants shared by the zero-suppress XOR block decoder.
// ----------------------------------------------------------------------------
package zsxd_pkg;

  localparam int BYTE_W = 8;

  // Token bits per group, last byte position in a block and in a word.
  localparam logic [3:0] TOKEN_BITS     = 4'd8;
  localparam logic [4:0] BLOCK_LAST_POS = 5'd31;
  localparam logic [1:0] WORD_LAST_POS  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WORK = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take the accepted item into the datapath
    logic step;    // emit one decoded byte into the output register
    logic finish;  // the item is done; clear state if it was the final one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic avail;   // a byte can be emitted now
    logic more;    // after this byte, another one follows for the same item
  } status_t;

endpackage

### sv/zsxd_in_if.sv
// ----------------------------------------------------------------------------
// zsxd_in_if
// Compressed byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface zsxd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

### sv/zsxd_out_if.sv
// ----------------------------------------------------------------------------
// zsxd_out_if
// Decoded byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface zsxd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       block_last;

  modport source (output valid, output out_byte, output run_last, output block_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input block_last,
                  output ready);
endinterface

### sv/zsxd_datapath.sv
// ----------------------------------------------------------------------------
// zsxd_datapath
// Token bookkeeping, XOR chaining by 32-bit word and the output register.
// ----------------------------------------------------------------------------
module zsxd_datapath
  import zsxd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [7:0] in_byte,
  input  logic       last_in,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       block_last
);

  logic [7:0]  token_bits;
  logic [3:0]  bits_left;
  logic [4:0]  byte_in_block;
  logic [31:0] prev_word;
  logic [31:0] cur_word;
  logic [7:0]  lit;
  logic        lit_pending;
  logic        last_r;

  logic        zero_bit;
  logic        pad;
  logic [7:0]  raw;
  logic [1:0]  lane;
  logic [4:0]  lane_ofs;
  logic [7:0]  dec;
  logic [31:0] cur_word_next;
  logic [7:0]  token_bits_next;
  logic [3:0]  bits_left_next;
  logic [4:0]  byte_in_block_next;
  logic        block_end;

  always_comb begin
    zero_bit = (bits_left != 4'd0) && !token_bits[7];
    // Padding completes a started block with zero raw bytes on the final item.
    pad      = !lit_pending && !zero_bit && last_r
               && ((bits_left != 4'd0) || (byte_in_block != 5'd0));
    raw      = lit_pending ? lit : 8'd0;
    lane     = 2'(WORD_LAST_POS - byte_in_block[1:0]);
    lane_ofs = {lane, 3'b000};
    dec      = raw ^ prev_word[lane_ofs +: 8];
    cur_word_next = cur_word;
    cur_word_next[lane_ofs +: 8] = dec;
    if (pad) begin
      token_bits_next = token_bits;
      bits_left_next  = 4'd0;
    end else begin
      token_bits_next = {token_bits[6:0], 1'b0};
      bits_left_next  = bits_left - 4'd1;
    end
    byte_in_block_next = byte_in_block + 5'd1;
    block_end          = (byte_in_block == BLOCK_LAST_POS);

    status.avail = lit_pending || zero_bit || pad;
    status.more  = ((bits_left_next != 4'd0) && !token_bits_next[7])
                   || (last_r && ((bits_left_next != 4'd0) || (byte_in_block_next != 5'd0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_bits    <= 8'd0;
      bits_left     <= 4'd0;
      byte_in_block <= 5'd0;
      prev_word     <= 32'd0;
      cur_word      <= 32'd0;
      lit_pending   <= 1'b0;
      last_r        <= 1'b0;
    end else if (cmd.load) begin
      last_r <= last_in;
      if (bits_left == 4'd0) begin
        token_bits  <= in_byte;
        bits_left   <= TOKEN_BITS;
        lit_pending <= 1'b0;
      end else begin
        lit         <= in_byte;
        lit_pending <= 1'b1;
      end
    end else if (cmd.finish && last_r) begin
      // The final item leaves all state at its reset values.
      token_bits    <= 8'd0;
      bits_left     <= 4'd0;
      byte_in_block <= 5'd0;
      prev_word     <= 32'd0;
      cur_word      <= 32'd0;
      lit_pending   <= 1'b0;
      last_r        <= 1'b0;
    end else if (cmd.step) begin
      token_bits    <= token_bits_next;
      bits_left     <= bits_left_next;
      byte_in_block <= byte_in_block_next;
      lit_pending   <= 1'b0;
      if (block_end) begin
        prev_word <= 32'd0;
        cur_word  <= 32'd0;
      end else begin
        cur_word <= cur_word_next;
        if (byte_in_block[1:0] == WORD_LAST_POS) begin
          prev_word <= cur_word_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte   <= dec;
      run_last   <= !status.more;
      block_last <= block_end;
    end
  end

  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    bits_left <= TOKEN_BITS)
    else $error("token bit count out of range");

  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.step && block_end |=> byte_in_block == 5'd0 && prev_word == 32'd0
                              && cur_word == 32'd0)
    else $error("block end did not clear the word chain");

  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && last_r && !cmd.load |=> bits_left == 4'd0 && byte_in_block == 5'd0
                                          && !lit_pending)
    else $error("final item left decoder state behind");

endmodule

### sv/zsxd_ctrl.sv
// ----------------------------------------------------------------------------
// zsxd_ctrl
// Controller: takes one item, emits its bytes one per cycle when not stalled.
// ----------------------------------------------------------------------------
module zsxd_ctrl
  import zsxd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    slot_free      = !out_valid || out_ready;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (!status.avail) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (slot_free) begin
          cmd.step       = 1'b1;
          out_valid_next = 1'b1;
          if (!status.more) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_step_avail: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> status.avail && slot_free)
    else $error("byte emitted with nothing to emit or no room");

  a_load_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_WORK)
    else $error("accepted item did not start work");

  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    state == S_WORK && !status.avail |=> state == S_IDLE)
    else $error("controller stuck with nothing to emit");

endmodule

### sv/zero_suppress_xor_block_decoder.sv
// ----------------------------------------------------------------------------
// zero_suppress_xor_block_decoder
// Zero-suppressed token decoder with per-block 32-bit XOR chaining.
// ----------------------------------------------------------------------------
// One compressed byte is taken per item. The block first takes the item, then
// emits the decoded bytes that it produces one per cycle when not stalled, n
// from 0 to 32 bytes per item. A token of all zero bits gives eight bytes
// before the next item is taken, and a final item can pad out up to a whole
// 32-byte block. A decoded byte waits in the output register while the next
// item is taken, and the emit loop stalls only while that register is full
// and not taken.
// ----------------------------------------------------------------------------
module zero_suppress_xor_block_decoder
  import zsxd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  zsxd_in_if.sink  in_ch,
  zsxd_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  zsxd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  zsxd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_byte    (in_ch.in_byte),
    .last_in    (in_ch.last_in),
    .out_byte   (out_ch.out_byte),
    .run_last   (out_ch.run_last),
    .block_last (out_ch.block_last)
  );

endmodule
